// ===== sv/ebi_pkg.sv =====
// ----------------------------------------------------------------------------
// ebi_pkg
// Shared types and codes for the exon boundary inference block: site kinds,
// error codes, result selectors and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ebi_pkg;

    localparam int SITE_BITS     = 32;
    localparam int GAP_BITS      = 20;
    localparam logic [GAP_BITS-1:0] GAP_RESET = 20'd400;
    localparam int OUT_DATA_BITS = 128;
    localparam int OUT_USER_BITS = 5;

    // site kinds
    localparam logic [1:0] KIND_EXON_START = 2'd0;
    localparam logic [1:0] KIND_JUNC_END   = 2'd1;
    localparam logic [1:0] KIND_JUNC_START = 2'd2;
    localparam logic [1:0] KIND_EXON_END   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_START = 2'd1;
    localparam logic [1:0] ERR_LEFTOVER = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // result selectors
    localparam logic [1:0] EMIT_EXON = 2'd0;
    localparam logic [1:0] EMIT_ACC  = 2'd1;
    localparam logic [1:0] EMIT_HALF = 2'd2;
    localparam logic [1:0] EMIT_ERR  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       flush_start;
        logic       flush_next;
        logic       ram_re;
        logic       emit;
        logic [1:0] emit_sel;
        logic [1:0] err_code;
        logic       last;
        logic       update;
        logic       gene_clear;
    } ebi_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       done;
        logic       in_annot;
        logic       cur_valid;
        logic       past;
        logic       near;
        logic       count_zero;
        logic       count_full;
        logic       flush_last;
        logic       slot_free;
    } ebi_status_t;

endpackage

// ===== sv/ebi_ram.sv =====
// ----------------------------------------------------------------------------
// ebi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ebi_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ebi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebi_ctrl
// Sequencer: plans the results of one site item, then walks the result
// phases in order, the state update and the end-of-gene phases.
// ----------------------------------------------------------------------------
module ebi_ctrl
    import ebi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ebi_status_t st,
    output ebi_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECIDE   = 4'd1;
    localparam logic [3:0] ST_PRE_E    = 4'd2;
    localparam logic [3:0] ST_FL_RD    = 4'd3;
    localparam logic [3:0] ST_FL_WR    = 4'd4;
    localparam logic [3:0] ST_POST_E   = 4'd5;
    localparam logic [3:0] ST_HALF     = 4'd6;
    localparam logic [3:0] ST_ERR_ITEM = 4'd7;
    localparam logic [3:0] ST_UPDATE   = 4'd8;
    localparam logic [3:0] ST_ERR2     = 4'd9;
    localparam logic [3:0] ST_FIN_E    = 4'd10;
    localparam logic [3:0] ST_CLEAR    = 4'd11;

    typedef struct packed {
        logic       pre_e;
        logic       flush;
        logic       post_e;
        logic       half;
        logic       err_item;
        logic [1:0] err_code;
        logic       err2;
        logic       fin_e;
        logic       done;
    } plan_t;

    logic [3:0] state_reg, state_next;
    plan_t      plan_reg, plan_next, plan_new;

    function automatic logic [3:0] next_after(plan_t p, logic [3:0] cur);
        logic [3:0] nx;
        if (cur < ST_PRE_E && p.pre_e)
            nx = ST_PRE_E;
        else if (cur < ST_FL_RD && p.flush)
            nx = ST_FL_RD;
        else if (cur < ST_POST_E && p.post_e)
            nx = ST_POST_E;
        else if (cur < ST_HALF && p.half)
            nx = ST_HALF;
        else if (cur < ST_ERR_ITEM && p.err_item)
            nx = ST_ERR_ITEM;
        else if (cur < ST_UPDATE)
            nx = ST_UPDATE;
        else if (cur < ST_ERR2 && p.err2)
            nx = ST_ERR2;
        else if (cur < ST_FIN_E && p.fin_e)
            nx = ST_FIN_E;
        else if (p.done)
            nx = ST_CLEAR;
        else
            nx = ST_IDLE;
        return nx;
    endfunction

    // true when a result phase after cur is still to come
    function automatic logic more_after(plan_t p, logic [3:0] cur);
        logic m;
        m = (cur < ST_POST_E && p.post_e) || (cur < ST_HALF && p.half) ||
            (cur < ST_ERR_ITEM && p.err_item) || (cur < ST_ERR2 && p.err2) ||
            (cur < ST_FIN_E && p.fin_e) || (cur < ST_FL_RD && p.flush);
        return m;
    endfunction

    // plan from the state before the item is applied
    always_comb
    begin
        plan_new      = '0;
        plan_new.done = st.done;
        if (st.in_annot)
        begin
            plan_new.err2  = st.done && !st.count_zero;
            plan_new.fin_e = st.done && (st.kind == KIND_EXON_END);
        end
        else
        begin
            case (st.kind)
                KIND_EXON_START:
                begin
                    plan_new.pre_e = st.cur_valid;
                    plan_new.flush = st.past && !st.count_zero;
                end
                KIND_JUNC_END:
                begin
                    plan_new.pre_e    = st.cur_valid;
                    plan_new.flush    = st.past && !st.count_zero;
                    plan_new.err_item = !st.past && st.count_full;
                    plan_new.err_code = ERR_OVERFLOW;
                    plan_new.err2     = st.done;
                end
                KIND_JUNC_START:
                begin
                    if (st.near)
                    begin
                        plan_new.err2  = st.done && !st.count_zero;
                        plan_new.fin_e = st.done;
                    end
                    else if (!st.past)
                    begin
                        plan_new.fin_e = st.done;
                    end
                    else
                    begin
                        plan_new.flush  = !st.count_zero;
                        plan_new.post_e = st.cur_valid;
                        plan_new.half   = 1'b1;
                    end
                end
                default:
                begin
                    plan_new.err_item = 1'b1;
                    plan_new.err_code = ERR_NO_START;
                    plan_new.err2     = st.done && !st.count_zero;
                    plan_new.fin_e    = st.done && st.cur_valid;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        plan_next  = plan_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.flush_start = 1'b1;
                plan_next       = plan_new;
                state_next      = next_after(plan_new, ST_DECIDE);
            end
            ST_PRE_E, ST_POST_E, ST_FIN_E:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_EXON;
                    cmd.last     = !more_after(plan_reg, state_reg);
                    state_next   = next_after(plan_reg, state_reg);
                end
            end
            ST_HALF:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_HALF;
                    cmd.last     = !more_after(plan_reg, state_reg);
                    state_next   = next_after(plan_reg, state_reg);
                end
            end
            ST_ERR_ITEM:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_ERR;
                    cmd.err_code = plan_reg.err_code;
                    cmd.last     = !more_after(plan_reg, state_reg);
                    state_next   = next_after(plan_reg, state_reg);
                end
            end
            ST_ERR2:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_ERR;
                    cmd.err_code = ERR_LEFTOVER;
                    cmd.last     = !more_after(plan_reg, state_reg);
                    state_next   = next_after(plan_reg, state_reg);
                end
            end
            ST_FL_RD:
            begin
                cmd.ram_re = 1'b1;
                state_next = ST_FL_WR;
            end
            ST_FL_WR:
            begin
                // hold the read data until the output slot frees up
                if (st.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EMIT_ACC;
                    cmd.flush_next = 1'b1;
                    cmd.last       = st.flush_last && !more_after(plan_reg, ST_FL_WR);
                    state_next     = st.flush_last ? next_after(plan_reg, ST_FL_WR)
                                                   : ST_FL_RD;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = next_after(plan_reg, ST_UPDATE);
            end
            ST_CLEAR:
            begin
                cmd.gene_clear = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plan_reg  <= plan_next;
        end
    end

endmodule

// ===== sv/ebi_datapath.sv =====
// ----------------------------------------------------------------------------
// ebi_datapath
// Item registers, open-exon state, acceptor buffer with its first/last
// copies, distance compares and the output register.
// ----------------------------------------------------------------------------
module ebi_datapath
    import ebi_pkg::*;
#(
    parameter int ACCEPTOR_DEPTH = 16,
    parameter int POSITION_BITS  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [SITE_BITS-1:0]     s_tdata,
    input  logic [1:0]               s_tuser,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic [OUT_USER_BITS-1:0] m_tuser,
    output logic                     m_tlast,
    input  logic                     cfg_we,
    input  logic [GAP_BITS-1:0]      cfg_wdata,
    input  ebi_cmd_t                 cmd,
    output ebi_status_t              st
);

    localparam int PW = (POSITION_BITS < SITE_BITS) ? POSITION_BITS : SITE_BITS;
    localparam int SW = ((PW > GAP_BITS) ? PW : GAP_BITS) + 1;
    localparam int CW = $clog2(ACCEPTOR_DEPTH + 1);
    localparam int AW = (ACCEPTOR_DEPTH > 1) ? $clog2(ACCEPTOR_DEPTH) : 1;

    logic [GAP_BITS-1:0] max_gap_reg, max_gap_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [1:0]          kind_reg, kind_next;
    logic                done_reg, done_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       flush_idx_reg, flush_idx_next;
    logic [PW-1:0]       first_reg, first_next;
    logic [PW-1:0]       last_reg, last_next;
    logic [PW-1:0]       cur_start_reg, cur_start_next;
    logic [PW-1:0]       cur_end_reg, cur_end_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [PW-1:0]       ann_start_reg, ann_start_next;
    logic [PW-1:0]       ann_end_reg, ann_end_next;
    logic                ann_valid_reg, ann_valid_next;
    logic                inside_reg, inside_next;

    logic                out_valid_reg, out_valid_next;
    logic [PW-1:0]       out_start_reg, out_start_next;
    logic [PW-1:0]       out_end_reg, out_end_next;
    logic [PW-1:0]       out_as_reg, out_as_next;
    logic [PW-1:0]       out_ae_reg, out_ae_next;
    logic [OUT_USER_BITS-1:0] out_user_reg, out_user_next;
    logic                out_last_reg, out_last_next;

    logic [SW-1:0]       last_sum, end_sum, pos_ext;
    logic                past, near, count_zero, count_full, slot_free;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [PW-1:0]       ram_rdata;

    ebi_ram #(
        .WIDTH (PW),
        .DEPTH (ACCEPTOR_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pos_reg),
        .re    (cmd.ram_re),
        .raddr (flush_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pos_ext    = SW'(pos_reg);
    assign last_sum   = SW'(last_reg) + SW'(max_gap_reg);
    assign end_sum    = SW'(cur_end_reg) + SW'(max_gap_reg);
    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CW'(ACCEPTOR_DEPTH));
    assign past       = count_zero || (last_sum < pos_ext);
    assign near       = cur_valid_reg && !(end_sum < pos_ext);
    assign slot_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        st.kind       = kind_reg;
        st.done       = done_reg;
        st.in_annot   = inside_reg;
        st.cur_valid  = cur_valid_reg;
        st.past       = past;
        st.near       = near;
        st.count_zero = count_zero;
        st.count_full = count_full;
        st.flush_last = (CW'(flush_idx_reg + CW'(1)) == count_reg);
        st.slot_free  = slot_free;
    end

    // item load, state update and gene clear
    always_comb
    begin
        max_gap_next   = cfg_we ? cfg_wdata : max_gap_reg;
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        done_next      = done_reg;
        count_next     = count_reg;
        flush_idx_next = flush_idx_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        cur_start_next = cur_start_reg;
        cur_end_next   = cur_end_reg;
        cur_valid_next = cur_valid_reg;
        ann_start_next = ann_start_reg;
        ann_end_next   = ann_end_reg;
        ann_valid_next = ann_valid_reg;
        inside_next    = inside_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];

        if (cmd.load)
        begin
            pos_next  = s_tdata[PW-1:0];
            kind_next = s_tuser;
            done_next = s_tlast;
        end
        if (cmd.flush_start)
        begin
            flush_idx_next = '0;
        end
        if (cmd.flush_next)
        begin
            flush_idx_next = CW'(flush_idx_reg + CW'(1));
        end

        if (cmd.update)
        begin
            if (inside_reg)
            begin
                if (kind_reg == KIND_EXON_END)
                begin
                    cur_end_next = pos_reg;
                    ann_end_next = pos_reg;
                    inside_next  = 1'b0;
                end
            end
            else
            begin
                case (kind_reg)
                    KIND_EXON_START:
                    begin
                        cur_start_next = past ? pos_reg : first_reg;
                        cur_end_next   = '0;
                        ann_start_next = pos_reg;
                        ann_end_next   = '0;
                        cur_valid_next = 1'b1;
                        ann_valid_next = 1'b1;
                        inside_next    = 1'b1;
                        count_next     = '0;
                    end
                    KIND_JUNC_END:
                    begin
                        cur_start_next = '0;
                        cur_end_next   = '0;
                        ann_start_next = '0;
                        ann_end_next   = '0;
                        cur_valid_next = 1'b0;
                        ann_valid_next = 1'b0;
                        if (past)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            count_next = CW'(1);
                            first_next = pos_reg;
                            last_next  = pos_reg;
                        end
                        else if (!count_full)
                        begin
                            ram_we     = 1'b1;
                            count_next = CW'(count_reg + CW'(1));
                            last_next  = pos_reg;
                        end
                    end
                    KIND_JUNC_START:
                    begin
                        if (near)
                        begin
                            cur_end_next = pos_reg;
                        end
                        else if (!past)
                        begin
                            cur_start_next = first_reg;
                            cur_end_next   = pos_reg;
                            cur_valid_next = 1'b1;
                            ann_valid_next = 1'b0;
                            ann_start_next = '0;
                            ann_end_next   = '0;
                            count_next     = '0;
                        end
                        else
                        begin
                            count_next     = '0;
                            cur_start_next = '0;
                            cur_end_next   = '0;
                            ann_start_next = '0;
                            ann_end_next   = '0;
                            cur_valid_next = 1'b0;
                            ann_valid_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        // stray exon end: only an error result
                    end
                endcase
            end
        end

        if (cmd.gene_clear)
        begin
            count_next     = '0;
            cur_start_next = '0;
            cur_end_next   = '0;
            ann_start_next = '0;
            ann_end_next   = '0;
            cur_valid_next = 1'b0;
            ann_valid_next = 1'b0;
            inside_next    = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_as_next    = out_as_reg;
        out_ae_next    = out_ae_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.last;
            out_start_next = '0;
            out_end_next   = '0;
            out_as_next    = '0;
            out_ae_next    = '0;
            out_user_next  = '0;
            case (cmd.emit_sel)
                EMIT_EXON:
                begin
                    out_start_next = cur_start_reg;
                    out_end_next   = cur_end_reg;
                    if (ann_valid_reg)
                    begin
                        out_as_next = ann_start_reg;
                        out_ae_next = ann_end_reg;
                    end
                    out_user_next  = {ERR_NONE, ann_valid_reg, 1'b1, 1'b1};
                end
                EMIT_ACC:
                begin
                    out_start_next = ram_rdata;
                    out_user_next  = {ERR_NONE, 1'b0, 1'b0, 1'b1};
                end
                EMIT_HALF:
                begin
                    out_end_next  = pos_reg;
                    out_user_next = {ERR_NONE, 1'b0, 1'b1, 1'b0};
                end
                default:
                begin
                    out_user_next = {cmd.err_code, 1'b0, 1'b0, 1'b0};
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {SITE_BITS'(out_ae_reg), SITE_BITS'(out_as_reg),
                       SITE_BITS'(out_end_reg), SITE_BITS'(out_start_reg)};
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg   <= GAP_RESET;
            count_reg     <= '0;
            flush_idx_reg <= '0;
            cur_start_reg <= '0;
            cur_end_reg   <= '0;
            cur_valid_reg <= 1'b0;
            ann_start_reg <= '0;
            ann_end_reg   <= '0;
            ann_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_gap_reg   <= max_gap_next;
            count_reg     <= count_next;
            flush_idx_reg <= flush_idx_next;
            cur_start_reg <= cur_start_next;
            cur_end_reg   <= cur_end_next;
            cur_valid_reg <= cur_valid_next;
            ann_start_reg <= ann_start_next;
            ann_end_reg   <= ann_end_next;
            ann_valid_reg <= ann_valid_next;
            inside_reg    <= inside_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        kind_reg      <= kind_next;
        done_reg      <= done_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_as_reg    <= out_as_next;
        out_ae_reg    <= out_ae_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== sv/exon_boundary_inference_core.sv =====
// ----------------------------------------------------------------------------
// exon_boundary_inference_core
// Sweeps one gene's sorted splice-site items and emits inferred exons.
// ----------------------------------------------------------------------------
// Input stream (s_*): one splice-site item per transfer, tdata the position,
// tuser the site kind, tlast the gene's last site. Output stream (m_*): one
// inferred exon, half exon or error per transfer; tlast marks the last result
// an input item causes. max_gap is to be written through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
// Each item runs through a sequencer: accept, plan, a phase per result
// (a read and an emit phase per flushed acceptor, which is read back from
// the acceptor RAM), the state update and, on the gene's last item, any
// end-of-gene results and a clear phase. The next item is taken only when
// the sequencer is back in idle.
// Reset returns all gene state to empty and max_gap to 400; acceptor RAM
// contents are not cleared, as only entries written in the current run are
// read.
// A stalled receiver holds the output register; the sequencer waits in its
// result phase and the input side stays not ready until it moves on.
// ----------------------------------------------------------------------------
module exon_boundary_inference_core
    import ebi_pkg::*;
#(
    parameter int ACCEPTOR_DEPTH = 16,
    parameter int POSITION_BITS  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [SITE_BITS-1:0]     s_tdata,   // site_position
    input  logic [1:0]               s_tuser,   // site_kind
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // exon_start, exon_end, ann_start, ann_end
    output logic [OUT_USER_BITS-1:0] m_tuser,   // start_known, end_known, is_annotated,
                                                // error_code[1:0]
    output logic                     m_tlast,
    input  logic                     cfg_we,
    input  logic [GAP_BITS-1:0]      cfg_wdata
);

    ebi_cmd_t    cmd;
    ebi_status_t st;

    ebi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ebi_datapath #(
        .ACCEPTOR_DEPTH (ACCEPTOR_DEPTH),
        .POSITION_BITS  (POSITION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== tb/ebi_checker.sv =====
// ----------------------------------------------------------------------------
// ebi_checker
// Watches the site, result and configuration ports of the exon boundary
// inference core. Each accepted site is swept through a local copy of the
// gene state, and the exons, half exons and errors it must cause are queued.
// Each accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module ebi_checker
    import ebi_pkg::*;
#(
    parameter int ACCEPTOR_DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [SITE_BITS-1:0]     s_tdata,   // site_position
    input  logic [1:0]               s_tuser,   // site_kind
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,   // exon_start, exon_end, ann_start, ann_end
    input  logic [OUT_USER_BITS-1:0] m_tuser,   // start_known, end_known, is_annotated,
                                                // error_code[1:0]
    input  logic                     m_tlast,
    input  logic                     cfg_we,
    input  logic [GAP_BITS-1:0]      cfg_wdata,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic [31:0] exon_start;
        logic [31:0] exon_end;
        logic [31:0] ann_start;
        logic [31:0] ann_end;
        logic        start_known;
        logic        end_known;
        logic        is_annotated;
        logic [1:0]  error_code;
        logic        last_of_run;
    } exon_rec_t;

    exon_rec_t   expected_exons[$];
    exon_rec_t   item_exons[$];

    logic [31:0] acc_buf[ACCEPTOR_DEPTH];
    int unsigned acc_cnt;
    logic [31:0] cur_start;
    logic [31:0] cur_end;
    logic [31:0] ann_lo;
    logic [31:0] ann_hi;
    bit          cur_valid;
    bit          ann_valid;
    bit          skipping;
    logic [GAP_BITS-1:0] max_gap;

    int fails   = 0;
    int waiting = 0;

    assign fail_count = fails;
    assign pending    = waiting;

    // join test on 33 bits so that the sum never wraps
    function automatic bit joins(logic [31:0] lo, logic [31:0] hi);
        return ({1'b0, lo} + 33'(max_gap)) >= {1'b0, hi};
    endfunction

    function automatic void put_rec(logic [31:0] s, logic [31:0] e, logic sk, logic ek,
                                    logic [31:0] as_v, logic [31:0] ae_v, logic ia,
                                    logic [1:0] err);
        exon_rec_t rec;
        rec.exon_start   = s;
        rec.exon_end     = e;
        rec.start_known  = sk;
        rec.end_known    = ek;
        rec.ann_start    = as_v;
        rec.ann_end      = ae_v;
        rec.is_annotated = ia;
        rec.error_code   = err;
        rec.last_of_run  = 1'b0;
        item_exons.insert(item_exons.size(), rec);
    endfunction

    function automatic void clear_exon();
        cur_start = '0;
        cur_end   = '0;
        cur_valid = 1'b0;
        ann_lo    = '0;
        ann_hi    = '0;
        ann_valid = 1'b0;
    endfunction

    function automatic void emit_open();
        if (!cur_valid)
            return;
        put_rec(cur_start, cur_end, 1'b1, 1'b1, ann_valid ? ann_lo : 32'd0,
                ann_valid ? ann_hi : 32'd0, ann_valid, ERR_NONE);
        clear_exon();
    endfunction

    // flush buffered acceptors as open-ended halves when pos lies beyond them
    function automatic bit flush_if_past(logic [31:0] pos);
        bit past;
        past = 1'b1;
        if (acc_cnt != 0)
            past = !joins(acc_buf[acc_cnt - 1], pos);
        if (past)
        begin
            for (int i = 0; i < acc_cnt; i++)
                put_rec(acc_buf[i], 32'd0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, ERR_NONE);
            acc_cnt = 0;
        end
        return past;
    endfunction

    function automatic logic [31:0] take_first();
        logic [31:0] v;
        v = (acc_cnt != 0) ? acc_buf[0] : 32'd0;
        acc_cnt = 0;
        return v;
    endfunction

    task automatic predict_site(logic [31:0] pos, logic [1:0] kind, logic done);
        item_exons.delete();
        if (skipping)
        begin
            if (kind == KIND_EXON_END)
            begin
                cur_end  = pos;
                ann_hi   = pos;
                skipping = 1'b0;
            end
        end
        else
        begin
            case (kind)
                KIND_EXON_START:
                begin
                    emit_open();
                    if (flush_if_past(pos))
                        cur_start = pos;
                    else
                        cur_start = take_first();
                    ann_lo    = pos;
                    cur_valid = 1'b1;
                    ann_valid = 1'b1;
                    skipping  = 1'b1;
                end
                KIND_JUNC_END:
                begin
                    emit_open();
                    void'(flush_if_past(pos));
                    if (acc_cnt < ACCEPTOR_DEPTH)
                    begin
                        acc_buf[acc_cnt] = pos;
                        acc_cnt++;
                    end
                    else
                        put_rec('0, '0, 1'b0, 1'b0, '0, '0, 1'b0, ERR_OVERFLOW);
                end
                KIND_JUNC_START:
                begin
                    if (cur_valid && joins(cur_end, pos))
                        cur_end = pos;
                    else if (!flush_if_past(pos))
                    begin
                        cur_start = take_first();
                        cur_end   = pos;
                        cur_valid = 1'b1;
                        ann_valid = 1'b0;
                        ann_lo    = '0;
                        ann_hi    = '0;
                    end
                    else
                    begin
                        emit_open();
                        put_rec(32'd0, pos, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0, ERR_NONE);
                    end
                end
                default:
                    put_rec('0, '0, 1'b0, 1'b0, '0, '0, 1'b0, ERR_NO_START);
            endcase
        end

        if (done)
        begin
            // drop an annotated exon that never saw its end
            if (skipping)
            begin
                clear_exon();
                skipping = 1'b0;
            end
            if (acc_cnt != 0)
            begin
                put_rec('0, '0, 1'b0, 1'b0, '0, '0, 1'b0, ERR_LEFTOVER);
                acc_cnt = 0;
            end
            emit_open();
            clear_exon();
        end

        if (item_exons.size() > 0)
            item_exons[item_exons.size() - 1].last_of_run = 1'b1;
        foreach (item_exons[i])
            expected_exons.insert(expected_exons.size(), item_exons[i]);
    endtask

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        exon_rec_t got;
        exon_rec_t want;
        got.exon_start   = m_tdata[31:0];
        got.exon_end     = m_tdata[63:32];
        got.ann_start    = m_tdata[95:64];
        got.ann_end      = m_tdata[127:96];
        got.start_known  = m_tuser[0];
        got.end_known    = m_tuser[1];
        got.is_annotated = m_tuser[2];
        got.error_code   = m_tuser[4:3];
        got.last_of_run  = m_tlast;
        if (expected_exons.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got start %h end %h err %0d",
                     $time, got.exon_start, got.exon_end, got.error_code);
            fails++;
        end
        else
        begin
            want = expected_exons.pop_front();
            field_check("exon_start", want.exon_start, got.exon_start);
            field_check("exon_end", want.exon_end, got.exon_end);
            field_check("ann_start", want.ann_start, got.ann_start);
            field_check("ann_end", want.ann_end, got.ann_end);
            field_check("start_known", 32'(want.start_known), 32'(got.start_known));
            field_check("end_known", 32'(want.end_known), 32'(got.end_known));
            field_check("is_annotated", 32'(want.is_annotated), 32'(got.is_annotated));
            field_check("error_code", 32'(want.error_code), 32'(got.error_code));
            field_check("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt  = 0;
            skipping = 1'b0;
            max_gap  = GAP_RESET;
            clear_exon();
            expected_exons.delete();
            waiting  = 0;
        end
        else
        begin
            if (cfg_we)
                max_gap = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_site(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            waiting = expected_exons.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the exon boundary inference core. A short directed
// gene list covers stray exon ends, skipping inside annotated exons, leftover
// acceptors and positions at both ends of the range; random genes follow
// under several max_gap settings, with bursts of idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import ebi_pkg::*;

    localparam int ACC_DEPTH      = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [SITE_BITS-1:0]     s_tdata;      // site_position
    logic [1:0]               s_tuser;      // site_kind
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;      // exon_start, exon_end, ann_start, ann_end
    logic [OUT_USER_BITS-1:0] m_tuser;      // start_known, end_known, is_annotated,
                                            // error_code[1:0]
    logic                     m_tlast;
    logic                     cfg_we;
    logic [GAP_BITS-1:0]      cfg_wdata;

    int                       fail_count;
    int                       pending;
    int                       items_sent;
    bit                       idle_on;
    logic [GAP_BITS-1:0]      cur_gap;

    exon_boundary_inference_core #(
        .ACCEPTOR_DEPTH(ACC_DEPTH),
        .POSITION_BITS (SITE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    ebi_checker #(
        .ACCEPTOR_DEPTH(ACC_DEPTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall bursts while idling is enabled
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_site(logic [31:0] pos, logic [1:0] kind, logic done);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tdata  = pos;
        s_tuser  = kind;
        s_tlast  = done;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off until every expected result is out, then let the block settle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_gap(logic [GAP_BITS-1:0] value);
        drain();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        cur_gap   = value;
    endtask

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return KIND_EXON_START;
        else if (r < 10)
            return KIND_JUNC_END;
        else if (r < 17)
            return KIND_JUNC_START;
        return KIND_EXON_END;
    endfunction

    task automatic send_gene();
        logic [32:0] p;
        logic [32:0] step;
        logic [1:0]  k;
        logic [1:0]  nk;
        logic [31:0] pos_a[$];
        logic [1:0]  kind_a[$];
        int          sel;
        int          len;
        int          r;
        sel = $urandom_range(0, 19);
        r   = $urandom_range(0, 7);
        if (r == 0)
            p = 33'h0_FFFF_FFFF - 33'($urandom_range(0, 5000));
        else if (r == 1)
            p = 33'($urandom_range(0, 1000));
        else
            p = 33'($urandom_range(0, 32'hE000_0000));

        if (sel < 2)
        begin
            // acceptor run from just under to just past the buffer depth, then a distant donor
            len = $urandom_range(ACC_DEPTH - 1, ACC_DEPTH + 2);
            for (int i = 0; i < len; i++)
            begin
                p = p + 33'($urandom_range(1, (cur_gap == 0) ? 1 : cur_gap));
                if (p > 33'h0_FFFF_FFFF)
                    break;
                pos_a.insert(pos_a.size(), p[31:0]);
                kind_a.insert(kind_a.size(), KIND_JUNC_END);
            end
            p = p + 33'(cur_gap) + 33'($urandom_range(1, 1000));
            if (p <= 33'h0_FFFF_FFFF)
            begin
                pos_a.insert(pos_a.size(), p[31:0]);
                kind_a.insert(kind_a.size(), KIND_JUNC_START);
            end
        end
        else if (sel < 4)
        begin
            // noise: unsorted positions and arbitrary kinds
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                pos_a.insert(pos_a.size(), 32'($urandom));
                kind_a.insert(kind_a.size(), 2'($urandom_range(0, 3)));
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            k   = pick_kind();
            pos_a.insert(pos_a.size(), p[31:0]);
            kind_a.insert(kind_a.size(), k);
            for (int i = 1; i < len; i++)
            begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    step = '0;
                else if (r < 6)
                    step = 33'($urandom_range(0, cur_gap));
                else if (r < 8)
                    step = 33'(cur_gap) + 33'($urandom_range(1, 50));
                else if (r == 8)
                    step = 33'(cur_gap);
                else
                    step = 33'($urandom_range(0, 1 << 24));
                nk = pick_kind();
                // keep (position, kind) strictly rising
                if (step == '0 && nk <= k)
                begin
                    if (k == KIND_EXON_END)
                        step = 33'd1;
                    else
                        nk = 2'($urandom_range(k + 1, 3));
                end
                if (p + step > 33'h0_FFFF_FFFF)
                    break;
                p = p + step;
                k = nk;
                pos_a.insert(pos_a.size(), p[31:0]);
                kind_a.insert(kind_a.size(), k);
            end
        end

        if (pos_a.size() == 0)
        begin
            pos_a.insert(pos_a.size(), 32'hFFFF_FFFF);
            kind_a.insert(kind_a.size(), KIND_JUNC_END);
        end
        foreach (pos_a[i])
            send_site(pos_a[i], kind_a[i],
                      (i == pos_a.size() - 1) || (sel >= 2 && sel < 4 &&
                      $urandom_range(0, 3) == 0));

        if ($urandom_range(0, 5) == 0)
            drain();
    endtask

    task automatic run_phase(int target);
        int first;
        first = items_sent;
        while (items_sent - first < target)
            send_gene();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_EXON_START;
        s_tlast    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        items_sent = 0;
        idle_on    = 1'b1;
        cur_gap    = GAP_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // exon end with no open annotated exon
        send_site(32'd0, KIND_EXON_END, 1'b0);
        // acceptors joined into a denovo exon, then a distant donor
        send_site(32'd200, KIND_JUNC_END, 1'b0);
        send_site(32'd300, KIND_JUNC_END, 1'b0);
        send_site(32'd500, KIND_JUNC_START, 1'b0);
        send_site(32'd1000, KIND_JUNC_START, 1'b0);
        // annotated exon: inner sites are skipped until its end
        send_site(32'd2000, KIND_EXON_START, 1'b0);
        send_site(32'd2100, KIND_JUNC_END, 1'b0);
        send_site(32'd2200, KIND_JUNC_START, 1'b0);
        send_site(32'd2500, KIND_EXON_END, 1'b0);
        send_site(32'd2600, KIND_JUNC_START, 1'b1);
        // acceptor left over at gene end
        send_site(32'd5000, KIND_JUNC_END, 1'b1);
        // gene ends while inside an annotated exon
        send_site(32'd6000, KIND_EXON_START, 1'b1);
        // join across the top of the position range
        send_site(32'hFFFF_FF00, KIND_JUNC_END, 1'b0);
        send_site(32'hFFFF_FFFF, KIND_JUNC_START, 1'b1);
        // far apart at both ends of the range
        send_site(32'd0, KIND_JUNC_END, 1'b0);
        send_site(32'hFFFF_FFFF, KIND_JUNC_START, 1'b1);

        run_phase(20);
        write_gap('0);
        run_phase(20);
        write_gap({GAP_BITS{1'b1}});
        run_phase(20);
        write_gap(GAP_BITS'($urandom_range(1, 2000)));
        run_phase(20);
        idle_on = 1'b0;
        write_gap(GAP_RESET);
        run_phase(15);

        drain();
        repeat (20) @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
